[sv/zz_pkg.sv]
// Shared types and constants for the zigzag scan reorder unit.
package zz_pkg;

  localparam int MAX_ROWS_DEF  = 8;
  localparam int MAX_COLS_DEF  = 8;
  localparam int DATA_BITS_DEF = 16;

  localparam int POS_BITS       = 3;
  localparam int DIM_BITS       = 4;
  localparam int OUT_VALUE_BITS = 16;
  localparam int OUT_TDATA_BITS = 24;
  localparam int CFG_IDX_BITS   = 1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_NUM_ROWS = 1'b0,
    REG_NUM_COLS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                valid;
    logic [POS_BITS-1:0] row;
    logic [POS_BITS-1:0] col;
    logic                last;
  } zz_rd_t;

  typedef struct packed {
    logic [OUT_VALUE_BITS-1:0] value;
    logic [POS_BITS-1:0]       row;
    logic [POS_BITS-1:0]       col;
    logic                      last;
  } zz_out_t;

endpackage

[sv/zz_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module zz_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/zz_scan.sv]
// Zigzag position sequencer: walks the anti-diagonals and issues store reads.
module zz_scan #(
  parameter int AW = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          adv,
  input  logic [zz_pkg::POS_BITS-1:0]   rows_m1,
  input  logic [zz_pkg::POS_BITS-1:0]   cols_m1,
  input  logic [zz_pkg::DIM_BITS-1:0]   cols,
  output zz_pkg::zz_rd_t                rd,
  output logic [AW-1:0]                 raddr,
  output logic                          busy
);
  import zz_pkg::*;

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t              state;
  logic [POS_BITS-1:0] row;
  logic [POS_BITS-1:0] col;
  logic                up;
  logic                at_last;
  logic [7:0]          lin;

  assign at_last = (row == rows_m1) && (col == cols_m1);
  assign busy    = (state == S_RUN);

  assign rd.valid = busy && adv;
  assign rd.row   = row;
  assign rd.col   = col;
  assign rd.last  = at_last;

  assign lin   = 8'(row) * 8'(cols) + 8'(col);
  assign raddr = AW'(lin);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      row   <= '0;
      col   <= '0;
      up    <= 1'b1;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_RUN;
            row   <= '0;
            col   <= '0;
            up    <= 1'b1;
          end
        end
        S_RUN: begin
          if (adv) begin
            if (at_last) begin
              state <= S_IDLE;
            end else if (up) begin
              if (col == cols_m1) begin
                row <= row + 1'b1;
                up  <= 1'b0;
              end else if (row == '0) begin
                col <= col + 1'b1;
                up  <= 1'b0;
              end else begin
                row <= row - 1'b1;
                col <= col + 1'b1;
              end
            end else begin
              if (row == rows_m1) begin
                col <= col + 1'b1;
                up  <= 1'b1;
              end else if (col == '0) begin
                row <= row + 1'b1;
                up  <= 1'b1;
              end else begin
                row <= row + 1'b1;
                col <= col - 1'b1;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/zigzag_scan_reorder_unit.sv]
// Zigzag scan reorder unit: raster-order loader, block store and zigzag emitter.
//
//  channel | dir | handshake            | payload
//  s_      | in  | s_tvalid / s_tready  | s_tdata: element
//  m_      | out | m_tvalid / m_tready  | m_tdata: out_value, out_row, out_col; m_tlast: last
//  cfg_    | in  | cfg_valid / cfg_ready| cfg_index, cfg_data (num_rows, num_cols)
//
// Loading takes one word per cycle while s_tready is high; the word that completes a
// rows x cols block starts a scan that reads the store's read port once per cycle while
// the output buffer has room, and read data passes through the RAM output register into
// the output buffer. s_tready is low while the scan reads the store.
// Reset is synchronous; the store contents are not cleared. A stalled m_ side
// holds the scan through a two-entry output buffer.
module zigzag_scan_reorder_unit #(
  parameter int MAX_ROWS  = zz_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS  = zz_pkg::MAX_COLS_DEF,
  parameter int DATA_BITS = zz_pkg::DATA_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((DATA_BITS+7)/8)*8-1:0]      s_tdata,   // [DATA_BITS-1:0] element
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [zz_pkg::OUT_TDATA_BITS-1:0]   m_tdata,   // [15:0] value, [18:16] row, [21:19] col
  output logic                                m_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [zz_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [zz_pkg::DIM_BITS-1:0]         cfg_data
);
  import zz_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int PAD   = OUT_TDATA_BITS - OUT_VALUE_BITS - 2 * POS_BITS;

  logic [DIM_BITS-1:0] num_rows;
  logic [DIM_BITS-1:0] num_cols;
  logic [DIM_BITS-1:0] rows_eff;
  logic [DIM_BITS-1:0] cols_eff;
  logic [7:0]          total;
  logic [CW-1:0]       load_count;
  logic [CW-1:0]       load_count_next;
  logic                s_acc;
  logic                cfg_acc;
  logic                start;

  zz_rd_t              rd;
  logic [AW-1:0]       raddr;
  logic                busy;
  logic                adv;
  logic [DATA_BITS-1:0] rdata;

  logic                pend;
  zz_rd_t              pend_info;
  zz_out_t             buf_q [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          occ;
  logic                pop;
  logic [2:0]          entries;
  logic [DATA_BITS+OUT_VALUE_BITS-1:0] wide;
  zz_out_t             head;

  assign rows_eff = (num_rows == '0) ? DIM_BITS'(1) :
                    (num_rows > DIM_BITS'(MAX_ROWS)) ? DIM_BITS'(MAX_ROWS) : num_rows;
  assign cols_eff = (num_cols == '0) ? DIM_BITS'(1) :
                    (num_cols > DIM_BITS'(MAX_COLS)) ? DIM_BITS'(MAX_COLS) : num_cols;
  assign total    = 8'(rows_eff) * 8'(cols_eff);

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign s_tready  = !busy;
  assign s_acc     = s_tvalid && s_tready;

  assign load_count_next = load_count + 1'b1;
  assign start = s_acc && (8'(load_count_next) == total);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows   <= DIM_BITS'(8);
      num_cols   <= DIM_BITS'(8);
      load_count <= '0;
    end else if (cfg_acc) begin
      case (cfg_reg_t'(cfg_index))
        REG_NUM_ROWS: num_rows <= cfg_data;
        REG_NUM_COLS: num_cols <= cfg_data;
        default: ;
      endcase
      load_count <= '0;
    end else if (s_acc) begin
      load_count <= start ? '0 : load_count_next;
    end
  end

  zz_ram #(
    .WIDTH (DATA_BITS),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (s_acc),
    .waddr (AW'(load_count)),
    .wdata (s_tdata[DATA_BITS-1:0]),
    .re    (rd.valid),
    .raddr (raddr),
    .rdata (rdata)
  );

  zz_scan #(
    .AW (AW)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .adv     (adv),
    .rows_m1 (POS_BITS'(rows_eff - 1'b1)),
    .cols_m1 (POS_BITS'(cols_eff - 1'b1)),
    .cols    (cols_eff),
    .rd      (rd),
    .raddr   (raddr),
    .busy    (busy)
  );

  // credit check: buffered words plus the read in flight never exceed two
  assign pop     = m_tvalid && m_tready;
  assign entries = 3'(occ) + 3'(pend) - 3'(pop);
  assign adv     = (entries < 3'd2);

  assign wide = {{OUT_VALUE_BITS{1'b0}}, rdata};

  always_ff @(posedge clk) begin
    if (rst) begin
      pend   <= 1'b0;
      occ    <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      pend <= rd.valid;
      occ  <= 2'(entries);
      if (pend) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_info <= rd;
    if (pend) begin
      buf_q[wr_ptr] <= '{value: wide[OUT_VALUE_BITS-1:0], row: pend_info.row,
                         col: pend_info.col, last: pend_info.last};
    end
  end

  assign head     = buf_q[rd_ptr];
  assign m_tvalid = (occ != '0);
  assign m_tdata  = {{PAD{1'b0}}, head.col, head.row, head.value};
  assign m_tlast  = head.last;

  a_credit: assert property (@(posedge clk) disable iff (rst)
    (3'(occ) + 3'(pend)) <= 3'd2)
    else $error("output buffer overrun");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    !(s_acc && rd.valid))
    else $error("store write during scan read");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    8'(load_count) < total)
    else $error("load count beyond block size");

  a_last_ends_scan: assert property (@(posedge clk) disable iff (rst)
    rd.valid && rd.last |=> !busy)
    else $error("scan continues after last position");

endmodule

[verif/zigzag_scan_reorder_unit_test.sv]
// Self-checking testbench for the zigzag scan reorder unit: raster loads, zigzag scan checks.
`timescale 1ns / 100ps

module zigzag_scan_reorder_unit_test;
  import zz_pkg::*;

  localparam int STORE_WORDS = MAX_ROWS_DEF * MAX_COLS_DEF;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 20;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_WORDS = 110;

  logic                      clk;
  logic                      rst;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [15:0]               s_tdata;   // [15:0] element
  logic                      m_tvalid;
  logic                      m_tready;
  logic [OUT_TDATA_BITS-1:0] m_tdata;   // [15:0] value, [18:16] row, [21:19] col
  logic                      m_tlast;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_BITS-1:0]   cfg_index;
  logic [DIM_BITS-1:0]       cfg_data;

  zigzag_scan_reorder_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow state of the block
  logic [DIM_BITS-1:0]       rows_code = 4'd8;
  logic [DIM_BITS-1:0]       cols_code = 4'd8;
  logic [DATA_BITS_DEF-1:0]  block_mem [STORE_WORDS];
  int                        fill_count = 0;
  zz_out_t                   pending_scan [$];

  int  mismatch_count = 0;
  int  words_loaded = 0;
  int  words_checked = 0;
  int  blocks_scanned = 0;
  bit  steady_sender = 0;
  bit  hold_req = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int dim_of(input logic [DIM_BITS-1:0] code, input int max_dim);
    if (code == 0) return 1;
    if (code > max_dim) return max_dim;
    return int'(code);
  endfunction

  function automatic void apply_reg_write(input logic [CFG_IDX_BITS-1:0] idx,
                                          input logic [DIM_BITS-1:0] value);
    if (idx == REG_NUM_ROWS) rows_code = value;
    else if (idx == REG_NUM_COLS) cols_code = value;
    fill_count = 0;
  endfunction

  // store one raster word; on block completion queue the whole zigzag scan
  function automatic void load_element(input logic [DATA_BITS_DEF-1:0] value);
    int rows, cols, total, d, r, lo, hi, row, col, n;
    zz_out_t w;
    rows = dim_of(rows_code, MAX_ROWS_DEF);
    cols = dim_of(cols_code, MAX_COLS_DEF);
    total = rows * cols;
    if (fill_count >= total) fill_count = 0;
    block_mem[fill_count % STORE_WORDS] = value;
    fill_count++;
    if (fill_count < total) return;
    fill_count = 0;
    blocks_scanned++;
    n = 0;
    for (d = 0; d + 1 < rows + cols; d++) begin
      lo = (d + 1 > cols) ? d + 1 - cols : 0;
      hi = (d < rows - 1) ? d : rows - 1;
      for (r = lo; r <= hi; r++) begin
        row = d[0] ? r : hi - (r - lo);
        col = d - row;
        w.value = block_mem[(row * cols + col) % STORE_WORDS];
        w.row = row[POS_BITS-1:0];
        w.col = col[POS_BITS-1:0];
        w.last = (n + 1 == total);
        pending_scan.push_back(w);
        n++;
      end
    end
  endfunction

  always @(posedge clk) begin
    zz_out_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) apply_reg_write(cfg_index, cfg_data);
      if (s_tvalid && s_tready) begin
        load_element(s_tdata[DATA_BITS_DEF-1:0]);
        words_loaded++;
      end
      if (m_tvalid && m_tready) begin
        words_checked++;
        if (pending_scan.size() == 0) begin
          mismatch_count++;
          $display("%0t unexpected scan word: value %h row %0d col %0d last %b",
                   $time, m_tdata[15:0], m_tdata[18:16], m_tdata[21:19], m_tlast);
        end else begin
          want = pending_scan.pop_front();
          if (m_tdata[15:0] !== want.value || m_tdata[18:16] !== want.row ||
              m_tdata[21:19] !== want.col || m_tlast !== want.last) begin
            mismatch_count++;
            $display("%0t mismatch: expected value %h row %0d col %0d last %b,",
                     $time, want.value, want.row, want.col, want.last,
                     " got value %h row %0d col %0d last %b",
                     m_tdata[15:0], m_tdata[18:16], m_tdata[21:19], m_tlast);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t watchdog: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("status: fail");
    $finish;
  end

  // mostly short gaps, some none, a few long
  function automatic int random_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] random_element();
    int p;
    p = $urandom_range(0, 9);
    case (p)
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return ($urandom_range(0, 1) == 1) ? 16'hffff : 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin : receiver
    int run_len, gap, k;
    m_tready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        for (k = 1; k < HOLD_CYCLES; k++) @(negedge clk);
        hold_req = 0;
      end else begin
        run_len = $urandom_range(1, 16);
        m_tready <= 1'b1;
        repeat (run_len - 1) @(negedge clk);
        gap = random_gap();
        if (gap > 0) begin
          @(negedge clk);
          m_tready <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
    end
  end

  task automatic send_element(input logic [15:0] value);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata <= value;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    gap = steady_sender ? 0 : random_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_words(input int count);
    int k;
    for (k = 0; k < count; k++) send_element(random_element());
  endtask

  task automatic wait_for_idle();
    s_tvalid <= 1'b0;
    while (pending_scan.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [DIM_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic set_shape(input logic [DIM_BITS-1:0] rows, input logic [DIM_BITS-1:0] cols);
    wait_for_idle();
    write_reg(REG_NUM_ROWS, rows);
    write_reg(REG_NUM_COLS, cols);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_single_cell();
    set_shape(4'd1, 4'd1);
    send_element(16'h8000);
    send_element(16'h7fff);
    send_element(16'h0000);
    send_element(16'hffff);
  endtask

  // 0 reads as 1, codes above 8 read as 8
  task automatic test_out_of_range_shapes();
    set_shape(4'd0, 4'd15);
    send_words(8);
    set_shape(4'd15, 4'd0);
    send_words(8);
  endtask

  task automatic test_partial_block_discard();
    set_shape(4'd2, 4'd2);
    send_words(3);
    set_shape(4'd1, 4'd2);
    send_words(2);
  endtask

  task automatic test_output_backpressure();
    set_shape(4'd8, 4'd8);
    steady_sender = 1;
    hold_req = 1;
    send_words(2 * STORE_WORDS);
    steady_sender = 0;
  endtask

  task automatic test_drain_pause();
    set_shape(4'd4, 4'd4);
    send_words(16);
    wait_for_idle();
    send_words(16);
  endtask

  task automatic test_random_shapes();
    int sent, p, blocks, b, total;
    logic [DIM_BITS-1:0] rows, cols;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      p = $urandom_range(0, 99);
      if (p < 60) begin
        rows = 4'($urandom_range(1, 4));
        cols = 4'($urandom_range(1, 4));
      end else if (p < 85) begin
        rows = 4'($urandom_range(1, 8));
        cols = 4'($urandom_range(1, 8));
      end else if (p < 92) begin
        rows = 4'd8;
        cols = 4'd8;
      end else begin
        rows = ($urandom_range(0, 1) == 1) ? 4'd0 : 4'($urandom_range(9, 15));
        cols = 4'($urandom_range(0, 15));
      end
      set_shape(rows, cols);
      steady_sender = ($urandom_range(0, 3) == 0);
      total = dim_of(rows, MAX_ROWS_DEF) * dim_of(cols, MAX_COLS_DEF);
      blocks = (total >= 32) ? 1 : $urandom_range(1, 3);
      for (b = 0; b < blocks; b++) begin
        send_words(total);
        sent += total;
      end
      if (total > 1 && $urandom_range(0, 9) == 0) begin
        p = $urandom_range(1, total - 1);
        send_words(p);
        sent += p;
      end
    end
    steady_sender = 0;
  endtask

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_NUM_ROWS;
    cfg_data <= '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_single_cell();
    test_out_of_range_shapes();
    test_partial_block_discard();
    test_output_backpressure();
    test_drain_pause();
    test_random_shapes();

    wait_for_idle();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("covered %0d input words and %0d scan words over %0d blocks, shapes 1x1 to 8x8",
             words_loaded, words_checked, blocks_scanned);
    $display("with out-of-range size codes, discarded partial blocks and a %0d-cycle output hold",
             HOLD_CYCLES);
    if (mismatch_count == 0 && pending_scan.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d scan words missing", mismatch_count, pending_scan.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
sv/zz_pkg.sv
sv/zz_ram.sv
sv/zz_scan.sv
sv/zigzag_scan_reorder_unit.sv
verif/zigzag_scan_reorder_unit_test.sv
